>>> rtl/box_average_downscale_3x3_assert.svh
// Assertion macros used by the RTL of the 3x3 box-average downscaler.
`ifndef BOX_AVERAGE_DOWNSCALE_3X3_ASSERT_SVH
`define BOX_AVERAGE_DOWNSCALE_3X3_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BOXAVG3_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("box average downscaler: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define BOXAVG3_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("box average downscaler: property violated");

`endif

>>> rtl/boxavg3_pkg.sv
// Package with the constants, types and arithmetic helpers of the box-average downscaler.
package boxavg3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W     = 8;
    localparam int SIZE_W    = 12;
    localparam int NCH       = 3;
    localparam int GRP_W     = 10;
    localparam int COL_W     = 12;
    localparam int NBLK      = MAX_WIDTH / 3;
    localparam int BLK_W     = $clog2(NBLK);
    localparam int COL_POS_W = $clog2(MAX_WIDTH);
    localparam int ROW_POS_W = $clog2(MAX_HEIGHT);
    localparam int RAM_W     = NCH * COL_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);

    localparam int RESET_WIDTH  = 1920;
    localparam int RESET_HEIGHT = 1080;
    localparam int RESET_W_USED = (RESET_WIDTH / 3) * 3;
    localparam int RESET_H_USED = (RESET_HEIGHT / 3) * 3;

    // Reciprocal constants: floor(x/3) = (x*2731)>>13 for x < 8192,
    // floor(x/9) = (x*7282)>>16 for x < 32768.
    localparam int DIV3_MUL   = 2731;
    localparam int DIV3_SHIFT = 13;
    localparam int DIV9_MUL   = 7282;
    localparam int DIV9_SHIFT = 16;
    localparam int DIV9_MUL_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [NCH-1:0][GRP_W-1:0] grp_sum_t;
    typedef logic [NCH-1:0][COL_W-1:0] col_sum_t;
    typedef logic [NCH-1:0][PIX_W-1:0] pix_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        if (v < MIN_SIZE) begin
            return MIN_SIZE;
        end
        else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [SIZE_W-1:0] div3(input logic [SIZE_W-1:0] v);
        logic [2*SIZE_W-1:0] prod;
        prod = (2*SIZE_W)'(v) * (2*SIZE_W)'(DIV3_MUL);
        return SIZE_W'(prod >> DIV3_SHIFT);
    endfunction

    function automatic logic [PIX_W-1:0] div9(input logic [COL_W-1:0] x);
        logic [COL_W+DIV9_MUL_W-1:0] prod;
        prod = (COL_W+DIV9_MUL_W)'(x) * (COL_W+DIV9_MUL_W)'(DIV9_MUL);
        return PIX_W'(prod >> DIV9_SHIFT);
    endfunction

endpackage

>>> rtl/boxavg3_if.sv
// Handshake interfaces of the box-average downscaler: pixel input, average output, register writes.
interface boxavg3_pix_if;
    import boxavg3_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pix_blue;
    logic [PIX_W-1:0] pix_green;
    logic [PIX_W-1:0] pix_red;

    modport source (output valid, output pix_blue, output pix_green, output pix_red,
                    input ready);
    modport sink (input valid, input pix_blue, input pix_green, input pix_red,
                  output ready);
endinterface

interface boxavg3_avg_if;
    import boxavg3_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] avg_blue;
    logic [PIX_W-1:0] avg_green;
    logic [PIX_W-1:0] avg_red;
    logic             frame_last;

    modport source (output valid, output avg_blue, output avg_green, output avg_red,
                    output frame_last, input ready);
    modport sink (input valid, input avg_blue, input avg_green, input avg_red,
                  input frame_last, output ready);
endinterface

interface boxavg3_cfg_if;
    import boxavg3_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/boxavg3_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module boxavg3_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 682,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/box_average_downscale_3x3.sv
// Top level of the 3x3 box-average downscaler.
`include "box_average_downscale_3x3_assert.svh"

// The block takes RGB pixels of a frame in raster order on the pix channel and returns
// one averaged pixel on the avg channel for every non-overlapping 3x3 block, each
// channel being the floor of the block sum divided by nine; frame_last marks the final
// average of a frame. Trailing columns and rows that do not fill a block are consumed
// but produce nothing. One pixel is accepted every clock cycle for as long as results
// are taken. The column-sum memory sees one write and, below the top row of a block,
// one read per group of three pixels. After the bottom-right pixel of a block is
// accepted, its average passes through stage 1, stage 2 and the output register. The
// memory needs no clearing pass after reset, since the top row of each block overwrites
// its entry. Frame width and height (register indexes 0 and 1) are clamped to the range
// 3 to 2048 and should be written only while no pixel is in flight; the position within
// the frame is kept across such a write and wraps once it lies beyond the new size.
module box_average_downscale_3x3 (
    input  logic                 clk,
    input  logic                 rst_n,
    boxavg3_cfg_if.sink          cfg,
    boxavg3_pix_if.sink          pix,
    boxavg3_avg_if.source        avg
);

    import boxavg3_pkg::*;

    // Frame geometry, stored already clamped together with the derived limits.
    logic [SIZE_W-1:0]    w_size_reg, w_size_next;
    logic [SIZE_W-1:0]    w_used_reg, w_used_next;
    logic [BLK_W-1:0]     blk_last_reg, blk_last_next;
    logic [SIZE_W-1:0]    h_size_reg, h_size_next;
    logic [SIZE_W-1:0]    h_used_reg, h_used_next;
    logic [ROW_POS_W-1:0] row_last_reg, row_last_next;
    logic [SIZE_W-1:0]    w_clamp, h_clamp, w_quot, h_quot;

    // Position of the next pixel, with its block column and phases kept alongside.
    logic [COL_POS_W-1:0] col_reg, col_next;
    logic [1:0]           cp_reg, cp_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [ROW_POS_W-1:0] row_reg, row_next;
    logic [1:0]           rp_reg, rp_next;
    grp_sum_t             grp_reg, grp_next, grp_new;

    // Stage 1: memory read data is present; the column sum is updated and written back.
    logic                 s1_valid_reg, s1_valid_next;
    logic [BLK_W-1:0]     s1_blk_reg, s1_blk_next;
    logic [1:0]           s1_rp_reg, s1_rp_next;
    grp_sum_t             s1_grp_reg, s1_grp_next;
    logic                 s1_last_reg, s1_last_next;

    // Stage 2: complete block sum waiting for the divide by nine.
    logic                 s2_valid_reg, s2_valid_next;
    col_sum_t             s2_sum_reg, s2_sum_next;
    logic                 s2_last_reg, s2_last_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    pix_t                 out_avg_reg, out_avg_next;
    logic                 out_last_reg, out_last_next;

    pix_t                 pix_val;
    logic                 pix_fire, in_range, launch;
    logic [SIZE_W-1:0]    col_inc, row_inc;
    logic                 out_free, s2_free, s2_adv, s1_free, s1_adv;
    col_sum_t             ram_rdata, col_sum;
    logic                 ram_re;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    assign w_clamp = clamp_size(cfg.data, MAX_W_SIZE);
    assign h_clamp = clamp_size(cfg.data, MAX_H_SIZE);
    assign w_quot  = div3(w_clamp);
    assign h_quot  = div3(h_clamp);

    always_comb
    begin
        w_size_next   = w_size_reg;
        w_used_next   = w_used_reg;
        blk_last_next = blk_last_reg;
        h_size_next   = h_size_reg;
        h_used_next   = h_used_reg;
        row_last_next = row_last_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_FRAME_WIDTH:
                begin
                    w_size_next   = w_clamp;
                    w_used_next   = SIZE_W'(w_quot * 3);
                    blk_last_next = BLK_W'(w_quot - SIZE_W'(1));
                end
                REG_FRAME_HEIGHT:
                begin
                    h_size_next   = h_clamp;
                    h_used_next   = SIZE_W'(h_quot * 3);
                    row_last_next = ROW_POS_W'(SIZE_W'(h_quot * 3) - SIZE_W'(1));
                end
                default:
                begin
                    w_size_next = w_size_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake between the stages; a stage moves on when the next one is
    // free or is itself moving on in the same cycle.
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || avg.ready;
    assign s2_adv    = s2_valid_reg && out_free;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_adv    = s1_valid_reg && ((s1_rp_reg != 2'd2) || s2_free);
    assign s1_free   = !s1_valid_reg || s1_adv;
    assign pix.ready = s1_free;
    assign pix_fire  = pix.valid && pix.ready;

    // ------------------------------------------------------------------
    // Accept stage: group sum and frame position
    // ------------------------------------------------------------------
    assign pix_val[0] = pix.pix_blue;
    assign pix_val[1] = pix.pix_green;
    assign pix_val[2] = pix.pix_red;

    assign in_range = (SIZE_W'(col_reg) < w_used_reg) && (SIZE_W'(row_reg) < h_used_reg);
    assign launch   = pix_fire && in_range && (cp_reg == 2'd2);
    assign col_inc  = SIZE_W'(col_reg) + SIZE_W'(1);
    assign row_inc  = SIZE_W'(row_reg) + SIZE_W'(1);

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            if (cp_reg == 2'd0)
            begin
                grp_new[k] = GRP_W'(pix_val[k]);
            end
            else
            begin
                grp_new[k] = grp_reg[k] + GRP_W'(pix_val[k]);
            end
        end
    end

    always_comb
    begin
        grp_next = grp_reg;
        col_next = col_reg;
        cp_next  = cp_reg;
        blk_next = blk_reg;
        row_next = row_reg;
        rp_next  = rp_reg;
        if (pix_fire)
        begin
            if (in_range)
            begin
                grp_next = grp_new;
            end
            if (col_inc >= w_size_reg)
            begin
                // End of a row, or a position left beyond a narrowed width.
                col_next = '0;
                cp_next  = 2'd0;
                blk_next = '0;
                if (row_inc >= h_size_reg)
                begin
                    row_next = '0;
                    rp_next  = 2'd0;
                end
                else
                begin
                    row_next = ROW_POS_W'(row_inc);
                    rp_next  = (rp_reg == 2'd2) ? 2'd0 : rp_reg + 2'd1;
                end
            end
            else
            begin
                col_next = COL_POS_W'(col_inc);
                if (cp_reg == 2'd2)
                begin
                    cp_next  = 2'd0;
                    blk_next = blk_reg + BLK_W'(1);
                end
                else
                begin
                    cp_next = cp_reg + 2'd1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Column-sum memory. The top row of a block overwrites its entry, so a
    // read is only issued for the middle and bottom rows. Two accesses to
    // one entry lie at least three accepted pixels apart, and a stage-1
    // write always retires no later than the next accept, so the read
    // after a write never needs forwarding.
    // ------------------------------------------------------------------
    assign ram_re = launch && (rp_reg != 2'd0);

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            if (s1_rp_reg == 2'd0)
            begin
                col_sum[k] = COL_W'(s1_grp_reg[k]);
            end
            else
            begin
                col_sum[k] = ram_rdata[k] + COL_W'(s1_grp_reg[k]);
            end
        end
    end

    boxavg3_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NBLK)
    ) u_col_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_blk_reg),
        .wdata (col_sum),
        .re    (ram_re),
        .raddr (blk_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Pipeline stage control
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_blk_next   = s1_blk_reg;
        s1_rp_next    = s1_rp_reg;
        s1_grp_next   = s1_grp_reg;
        s1_last_next  = s1_last_reg;
        if (launch)
        begin
            s1_valid_next = 1'b1;
            s1_blk_next   = blk_reg;
            s1_rp_next    = rp_reg;
            s1_grp_next   = grp_new;
            s1_last_next  = (blk_reg == blk_last_reg) && (row_reg == row_last_reg);
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_sum_next   = s2_sum_reg;
        s2_last_next  = s2_last_reg;
        if (s1_adv && (s1_rp_reg == 2'd2))
        begin
            s2_valid_next = 1'b1;
            s2_sum_next   = col_sum;
            s2_last_next  = s1_last_reg;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_avg_next   = out_avg_reg;
        out_last_next  = out_last_reg;
        if (s2_adv)
        begin
            out_valid_next = 1'b1;
            for (int k = 0; k < NCH; k++)
            begin
                out_avg_next[k] = div9(s2_sum_reg[k]);
            end
            out_last_next = s2_last_reg;
        end
        else if (avg.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign avg.valid      = out_valid_reg;
    assign avg.avg_blue   = out_avg_reg[0];
    assign avg.avg_green  = out_avg_reg[1];
    assign avg.avg_red    = out_avg_reg[2];
    assign avg.frame_last = out_last_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_size_reg    <= SIZE_W'(RESET_WIDTH);
            w_used_reg    <= SIZE_W'(RESET_W_USED);
            blk_last_reg  <= BLK_W'(RESET_W_USED / 3 - 1);
            h_size_reg    <= SIZE_W'(RESET_HEIGHT);
            h_used_reg    <= SIZE_W'(RESET_H_USED);
            row_last_reg  <= ROW_POS_W'(RESET_H_USED - 1);
            col_reg       <= '0;
            cp_reg        <= 2'd0;
            blk_reg       <= '0;
            row_reg       <= '0;
            rp_reg        <= 2'd0;
            grp_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            w_size_reg    <= w_size_next;
            w_used_reg    <= w_used_next;
            blk_last_reg  <= blk_last_next;
            h_size_reg    <= h_size_next;
            h_used_reg    <= h_used_next;
            row_last_reg  <= row_last_next;
            col_reg       <= col_next;
            cp_reg        <= cp_next;
            blk_reg       <= blk_next;
            row_reg       <= row_next;
            rp_reg        <= rp_next;
            grp_reg       <= grp_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_blk_reg   <= s1_blk_next;
        s1_rp_reg    <= s1_rp_next;
        s1_grp_reg   <= s1_grp_next;
        s1_last_reg  <= s1_last_next;
        s2_sum_reg   <= s2_sum_next;
        s2_last_reg  <= s2_last_next;
        out_avg_reg  <= out_avg_next;
        out_last_reg <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BOXAVG3_ASSERT_IMP(a_no_rw_same_entry, clk, rst_n, s1_adv && ram_re, s1_blk_reg != blk_reg)
    `BOXAVG3_ASSERT_NXT(a_s2_holds_on_stall, clk, rst_n, s2_valid_reg && !out_free, s2_valid_reg)
    `BOXAVG3_ASSERT_IMP(a_row_start_phase, clk, rst_n, col_reg == '0, (cp_reg == 2'd0) && (blk_reg == '0))

endmodule
